/* rtl/bmp_pkg.sv */
package bmp_pkg;

	localparam int unsigned VAL_W = 30;
	localparam int unsigned ARG_W = 12;
	localparam logic [VAL_W-1:0] PRIME = 30'd998244353;
	localparam logic [VAL_W-1:0] EXPO = 30'd998244351;

	typedef enum logic [2:0] {
		INIT_FWD,
		INIT_POW,
		INIT_BWD,
		INIT_DONE
	} init_state_t;

	typedef struct packed {
		logic             zero;
		logic [ARG_W-1:0] top;
		logic [ARG_W-1:0] choose;
		logic [ARG_W-1:0] diff;
	} query_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
	} mul_req_t;

endpackage

/* rtl/binomial_mod_prime.sv */
// Binomial coefficient C(top, choose) mod 998244353. After reset the block
// fills its factorial tables and stalls requests until done; then one
// request per cycle while the receiver does not stall the output.
module binomial_mod_prime #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bmp_pkg::ARG_W-1:0] top,
	input  logic [bmp_pkg::ARG_W-1:0] choose,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bmp_pkg::VAL_W-1:0] value
);
	logic ready, q_valid, q_stall;
	bmp_pkg::query_t q_data;

	bmp_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk, .arst_n, .ready, .in_valid, .in_stall, .top, .choose,
		.q_valid, .q_stall, .q_data
	);

	bmp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .ready, .q_valid, .q_stall, .q_data,
		.out_valid, .out_stall, .value
	);

	a_no_accept_init: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> in_stall) else $error("request accepted during init");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> value < bmp_pkg::PRIME) else $error("value out of range");
endmodule

/* rtl/bmp_mulmod.sv */
module bmp_mulmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [bmp_pkg::VAL_W-1:0]  x,
	input  logic [bmp_pkg::VAL_W-1:0]  y,
	output logic [bmp_pkg::VAL_W-1:0]  p
);
	// three stages: product, barrett estimate, correction
	localparam int unsigned PW = 2 * bmp_pkg::VAL_W;
	localparam logic [32:0] MU = 33'd4619796750; // floor(2^62 / prime)
	logic [PW-1:0]             prod_s1;
	logic [31:0]               prod_s2;
	logic [bmp_pkg::VAL_W-1:0] qest_s2;
	logic [bmp_pkg::VAL_W-1:0] p_s3;
	logic [61:0]               qfull;
	logic [31:0]               rem;
	logic [31:0]               rem2;

	assign qfull = 62'(prod_s1[PW-1:bmp_pkg::VAL_W]) * 62'(MU);
	assign p = p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1 <= '0;
			prod_s2 <= '0;
			qest_s2 <= '0;
			p_s3 <= '0;
		end else if (en) begin
			prod_s1 <= PW'(x) * PW'(y);
			prod_s2 <= prod_s1[31:0];
			qest_s2 <= qfull[61:32];
			p_s3 <= rem2[bmp_pkg::VAL_W-1:0];
		end
	end

	// remainder stays below four times the prime, so 32 bits hold it exactly
	always_comb begin
		rem = prod_s2 - 32'(qest_s2) * 32'(bmp_pkg::PRIME);
		rem2 = rem;
		if (rem2 >= 32'(bmp_pkg::PRIME)) rem2 = rem2 - 32'(bmp_pkg::PRIME);
		if (rem2 >= 32'(bmp_pkg::PRIME)) rem2 = rem2 - 32'(bmp_pkg::PRIME);
		if (rem2 >= 32'(bmp_pkg::PRIME)) rem2 = rem2 - 32'(bmp_pkg::PRIME);
	end
endmodule

/* rtl/bmp_front.sv */
module bmp_front #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bmp_pkg::ARG_W-1:0] top,
	input  logic [bmp_pkg::ARG_W-1:0] choose,
	output logic                      q_valid,
	input  logic                      q_stall,
	output bmp_pkg::query_t           q_data
);
	localparam int unsigned QD = 4;
	bmp_pkg::query_t fifo_q [QD];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;
	bmp_pkg::query_t cls;

	assign in_stall = !ready || (cnt_q == 3'(QD));
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 3'd0;
	assign pop = q_valid && !q_stall;
	assign q_data = fifo_q[rp_q];

	always_comb begin
		cls.top = top;
		cls.choose = choose;
		cls.diff = top - choose;
		cls.zero = (choose > top) || (32'(top) >= TABLE_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= cls;
	end
endmodule

/* rtl/bmp_back.sv */
module bmp_back #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	output logic                      ready,
	input  logic                      q_valid,
	output logic                      q_stall,
	input  bmp_pkg::query_t           q_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bmp_pkg::VAL_W-1:0] value
);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned VW = bmp_pkg::VAL_W;
	localparam int unsigned LAT = 8; // table read, two multipliers, output register
	localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
	localparam logic [4:0] TOP_BIT = 5'(bmp_pkg::VAL_W - 1);

	logic [VW-1:0] fact_mem [TABLE_DEPTH];
	logic [VW-1:0] inv_mem [TABLE_DEPTH];

	bmp_pkg::init_state_t st_q, st_d;
	logic [AW-1:0] idx_q;
	logic [2:0]    wait_q;
	logic [VW-1:0] acc_q, base_q, cur_q;
	logic [4:0]    bit_q;
	logic          phase_q;

	logic          en;
	logic [VW-1:0] m1x, m1y, m1p, m2x, m2y, m2p;
	logic [VW-1:0] fa_s1, ib_s1, id_s1;
	logic [VW-1:0] id_s2, id_s3, id_s4;
	logic [LAT-2:0] vld;
	logic [LAT-2:0] zr;
	logic [VW-1:0] out_q;
	logic out_v_q;
	logic run;

	assign ready = (st_q == bmp_pkg::INIT_DONE);
	assign en = !(out_v_q && out_stall);
	assign run = ready && en;
	assign q_stall = !run;
	assign out_valid = out_v_q;
	assign value = out_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			bmp_pkg::INIT_FWD:  if (wait_q == 3'd3 && idx_q == LAST) st_d = bmp_pkg::INIT_POW;
			bmp_pkg::INIT_POW:  if (wait_q == 3'd3 && phase_q && bit_q == TOP_BIT)
				st_d = bmp_pkg::INIT_BWD;
			bmp_pkg::INIT_BWD:  if (wait_q == 3'd3 && idx_q == '0) st_d = bmp_pkg::INIT_DONE;
			bmp_pkg::INIT_DONE: st_d = st_q;
			default:            st_d = bmp_pkg::INIT_FWD;
		endcase
	end

	always_comb begin
		m1x = fa_s1;
		m1y = ib_s1;
		m2x = m1p;
		m2y = id_s4;
		unique case (st_q)
			bmp_pkg::INIT_FWD: begin
				m1x = cur_q;
				m1y = VW'(idx_q) + VW'(1);
			end
			bmp_pkg::INIT_POW: begin
				m1x = phase_q ? base_q : acc_q;
				m1y = base_q;
			end
			bmp_pkg::INIT_BWD: begin
				m1x = cur_q;
				m1y = VW'(idx_q);
			end
			default: ;
		endcase
	end

	bmp_mulmod u_m1 (.clk(clk), .arst_n(arst_n), .en(en || !ready), .x(m1x), .y(m1y), .p(m1p));
	bmp_mulmod u_m2 (.clk(clk), .arst_n(arst_n), .en(en), .x(m2x), .y(m2y), .p(m2p));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bmp_pkg::INIT_FWD;
			idx_q <= '0;
			wait_q <= '0;
			cur_q <= VW'(1);
			acc_q <= VW'(1);
			base_q <= '0;
			bit_q <= '0;
			phase_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (!ready) wait_q <= (wait_q == 3'd3) ? 3'd0 : wait_q + 3'd1;
			unique case (st_q)
				bmp_pkg::INIT_FWD: if (wait_q == 3'd3) begin
					if (idx_q == LAST) begin
						base_q <= cur_q;
						bit_q <= '0;
						phase_q <= 1'b0;
					end else begin
						cur_q <= m1p;
						idx_q <= idx_q + AW'(1);
					end
				end
				bmp_pkg::INIT_POW: if (wait_q == 3'd3) begin
					if (!phase_q) begin
						if (bmp_pkg::EXPO[bit_q]) acc_q <= m1p;
						phase_q <= 1'b1;
					end else begin
						base_q <= m1p;
						phase_q <= 1'b0;
						if (bit_q == TOP_BIT) cur_q <= acc_q;
						else bit_q <= bit_q + 5'd1;
					end
				end
				bmp_pkg::INIT_BWD: if (wait_q == 3'd3 && idx_q != '0) begin
					cur_q <= m1p;
					idx_q <= idx_q - AW'(1);
				end
				default: ;
			endcase
		end
	end

	// pow runs lsb first: acc*=base when bit set, base squared each bit
	always_ff @(posedge clk) begin
		if (st_q == bmp_pkg::INIT_FWD && wait_q == 3'd0) fact_mem[idx_q] <= cur_q;
		if (st_q == bmp_pkg::INIT_BWD && wait_q == 3'd0) inv_mem[idx_q] <= cur_q;
		if (run) begin
			fa_s1 <= fact_mem[AW'(q_data.top)];
			ib_s1 <= inv_mem[AW'(q_data.choose)];
			id_s1 <= inv_mem[AW'(q_data.diff)];
		end
		if (en) begin
			id_s2 <= id_s1;
			id_s3 <= id_s2;
			id_s4 <= id_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
			zr <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
		end else if (en) begin
			vld <= {vld[LAT-3:0], run && q_valid};
			zr <= {zr[LAT-3:0], q_data.zero};
			out_v_q <= vld[LAT-2];
			out_q <= zr[LAT-2] ? '0 : m2p;
		end
	end
endmodule

/* dv/binomial_mod_prime_checker.sv */
`timescale 1ns / 1ps
module binomial_mod_prime_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [bmp_pkg::ARG_W-1:0] top,
	input  logic [bmp_pkg::ARG_W-1:0] choose,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [bmp_pkg::VAL_W-1:0] value,
	output int                        fail_count,
	output int                        pending
);
	localparam int DEPTH = 4096;
	localparam longint unsigned P = 64'd998244353;

	logic [bmp_pkg::VAL_W-1:0] fact_tab [DEPTH];
	logic [bmp_pkg::VAL_W-1:0] inv_fact_tab [DEPTH];
	logic [bmp_pkg::VAL_W-1:0] binom_q [$];

	function automatic logic [bmp_pkg::VAL_W-1:0] mulp(input longint unsigned x,
			input longint unsigned y);
		return bmp_pkg::VAL_W'((x * y) % P);
	endfunction

	function automatic logic [bmp_pkg::VAL_W-1:0] binom(input logic [11:0] a,
			input logic [11:0] b);
		if (b > a)
			return '0;
		return mulp(mulp(fact_tab[a], inv_fact_tab[b]), inv_fact_tab[a - b]);
	endfunction

	initial begin
		longint unsigned acc, base, e;
		fact_tab[0] = 1;
		for (int i = 1; i < DEPTH; i++)
			fact_tab[i] = mulp(fact_tab[i-1], longint'(i));
		acc = 1;
		base = fact_tab[DEPTH-1];
		e = P - 2;
		while (e != 0) begin
			if (e[0])
				acc = mulp(acc, base);
			base = mulp(base, base);
			e = e >> 1;
		end
		inv_fact_tab[DEPTH-1] = bmp_pkg::VAL_W'(acc);
		for (int i = DEPTH - 1; i > 0; i--)
			inv_fact_tab[i-1] = mulp(inv_fact_tab[i], longint'(i));
		fail_count = 0;
	end

	assign pending = binom_q.size();

	always @(posedge clk) begin
		logic [bmp_pkg::VAL_W-1:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (binom_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, value);
					fail_count++;
				end else begin
					want = binom_q.pop_front();
					if (value !== want) begin
						$display("%0t: value mismatch, expected %0d, actual %0d",
							$time, want, value);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				binom_q.push_back(binom(top, choose));
		end
	end
endmodule

/* dv/tb_binomial_mod_prime.sv */
`timescale 1ns / 1ps
module tb_binomial_mod_prime;
	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [bmp_pkg::ARG_W-1:0] top;
	logic [bmp_pkg::ARG_W-1:0] choose;
	logic                      out_valid;
	logic                      out_stall;
	logic [bmp_pkg::VAL_W-1:0] value;
	int                        fail_count;
	int                        pending;

	binomial_mod_prime dut (.*);
	binomial_mod_prime_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("binomial_mod_prime verification failed");
		$finish;
	end

	// receiver stall of random length after an accepted result
	initial begin
		int w;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 5));
				if (w > 0) begin
					out_stall <= 1'b1;
					repeat (w) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send(input logic [11:0] a, input logic [11:0] b, input bit gaps);
		int w;
		w = gaps ? int'($urandom_range(0, 5)) : 0;
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		top <= a;
		choose <= b;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		logic [11:0] a, b;
		bit gaps;
		in_valid = 1'b0;
		top = '0;
		choose = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(12'd0, 12'd0, 1'b0);
		send(12'd4095, 12'd0, 1'b0);
		send(12'd4095, 12'd4095, 1'b0);
		send(12'd4095, 12'd2047, 1'b0);
		send(12'd4095, 12'd2048, 1'b0);
		send(12'd4095, 12'd1, 1'b0);
		send(12'd4094, 12'd4095, 1'b0);
		send(12'd0, 12'd4095, 1'b0);
		send(12'd1, 12'd1, 1'b0);
		send(12'd1, 12'd2, 1'b0);
		send(12'd2048, 12'd1024, 1'b0);
		send(12'd3000, 12'd3001, 1'b0);
		send(12'hAAA, 12'h555, 1'b0);
		send(12'h555, 12'h2AA, 1'b0);
		for (int i = 0; i < 550; i++) begin
			gaps = ((i / 60) % 2) == 1;
			a = 12'($urandom_range(0, 4095));
			case ($urandom_range(0, 4))
				0: b = 12'($urandom_range(0, 4095));
				1: b = a;
				2: b = (a == 12'd4095) ? a : a + 12'd1;
				default: b = 12'($urandom_range(0, a));
			endcase
			send(a, b, gaps);
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("binomial_mod_prime verification clean");
		else
			$display("binomial_mod_prime verification failed");
		$finish;
	end
endmodule
